/* rtl/assert_macros.svh */
// assertion helpers for the mixer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ASSERT_ON(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ssdm_pkg.sv */
package ssdm_pkg;

  localparam int DIV_W   = 34;
  localparam int DVS_W   = 17;
  localparam int SPEED_W = 19;

  localparam logic [1:0] MODE_REVERSE = 2'd0;
  localparam logic [1:0] MODE_FORWARD = 2'd1;
  localparam logic [1:0] MODE_BRAKE   = 2'd2;

  localparam logic [2:0] CFG_DEADZONE       = 3'd0;
  localparam logic [2:0] CFG_SPIN_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_SPIN_SPEED     = 3'd2;
  localparam logic [2:0] CFG_DUTY_FULL      = 3'd3;
  localparam logic [2:0] CFG_DUTY_FLOOR     = 3'd4;

  // 100 percent in q8
  localparam logic [14:0] Q8_FULL = 15'd25600;
  localparam logic signed [16:0] STICK_POS_MAX = 17'sd32767;
  localparam logic signed [16:0] STICK_NEG_MAX = 17'sd32768;

  typedef struct packed {
    logic [7:0]         trigger_left;
    logic [7:0]         trigger_right;
    logic signed [15:0] joystick_x;
  } ssdm_in_t;

  typedef struct packed {
    logic [1:0] left_mode;
    logic [7:0] left_duty;
    logic [1:0] right_mode;
    logic [7:0] right_duty;
  } ssdm_out_t;

  typedef struct packed {
    logic [14:0] deadzone;
    logic [14:0] spin_threshold;
    logic [6:0]  spin_speed;
    logic [9:0]  duty_full;
    logic [9:0]  duty_floor;
  } ssdm_cfg_t;

  typedef enum logic [2:0] {
    OP_BRAKE,
    OP_STOP,
    OP_SPIN_RIGHT,
    OP_SPIN_LEFT,
    OP_STRAIGHT,
    OP_TURN_RIGHT,
    OP_TURN_LEFT
  } ssdm_op_t;

  typedef struct packed {
    ssdm_op_t    op;
    logic        diff_neg;
    logic [7:0]  diff_mag;
    logic [15:0] turn_num;
    logic [15:0] turn_den;
  } ssdm_cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DECODE,
    BK_SPEED,
    BK_INNER_GO,
    BK_INNER,
    BK_DUTY_L_GO,
    BK_DUTY_L,
    BK_DUTY_R_GO,
    BK_DUTY_R,
    BK_EMIT
  } ssdm_bk_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } ssdm_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } ssdm_div_rsp_t;

endpackage

/* rtl/ssdm_front.sv */
module ssdm_front #(
  parameter int TRIGGER_MAX = 255
) (
  input  ssdm_pkg::ssdm_in_t  item,
  input  logic [14:0]         deadzone,
  input  logic [14:0]         spin_threshold,
  output ssdm_pkg::ssdm_cmd_t cmd
);

  localparam logic [16:0] TMAX = 17'(TRIGGER_MAX);

  logic signed [16:0] x;
  logic signed [16:0] dz;
  logic signed [16:0] th;
  logic signed [16:0] num_right;
  logic signed [16:0] num_left;
  logic signed [16:0] den_right;
  logic signed [16:0] den_left;
  logic signed [8:0]  diff;
  logic [8:0]         diff_abs;
  logic               brake;
  logic               released;

  assign x  = {item.joystick_x[15], item.joystick_x};
  assign dz = signed'({2'b00, deadzone});
  assign th = signed'({2'b00, spin_threshold});

  assign num_right = x - dz;
  assign num_left  = -(x + dz);
  assign den_right = ssdm_pkg::STICK_POS_MAX - dz;
  assign den_left  = ssdm_pkg::STICK_NEG_MAX - dz;

  assign diff     = signed'({1'b0, item.trigger_right}) - signed'({1'b0, item.trigger_left});
  assign diff_abs = diff[8] ? 9'(-diff) : 9'(diff);

  assign brake    = ({9'd0, item.trigger_left} == TMAX) && ({9'd0, item.trigger_right} == TMAX);
  assign released = (item.trigger_left == 8'd0) && (item.trigger_right == 8'd0);

  always_comb begin
    cmd.diff_neg = diff[8];
    cmd.diff_mag = diff_abs[7:0];
    cmd.turn_num = 16'd0;
    cmd.turn_den = 16'd0;
    if (brake) begin
      cmd.op = ssdm_pkg::OP_BRAKE;
    end else if (released) begin
      if (x > th) begin
        cmd.op = ssdm_pkg::OP_SPIN_RIGHT;
      end else if (x < -th) begin
        cmd.op = ssdm_pkg::OP_SPIN_LEFT;
      end else begin
        cmd.op = ssdm_pkg::OP_STOP;
      end
    end else if (x > dz) begin
      cmd.op       = ssdm_pkg::OP_TURN_RIGHT;
      cmd.turn_num = num_right[15:0];
      cmd.turn_den = den_right[15:0];
    end else if (x < -dz) begin
      cmd.op       = ssdm_pkg::OP_TURN_LEFT;
      cmd.turn_num = num_left[15:0];
      cmd.turn_den = den_left[15:0];
    end else begin
      cmd.op = ssdm_pkg::OP_STRAIGHT;
    end
  end

endmodule

/* rtl/ssdm_fifo.sv */
module ssdm_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  ssdm_pkg::ssdm_cmd_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output ssdm_pkg::ssdm_cmd_t rd_data,
  output logic                empty
);

  ssdm_pkg::ssdm_cmd_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (rd_en) begin
        rptr <= ~rptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/ssdm_div.sv */
module ssdm_div (
  input  logic                    clk,
  input  logic                    rst,
  input  ssdm_pkg::ssdm_div_req_t req,
  output ssdm_pkg::ssdm_div_rsp_t rsp
);

  localparam int DIV_W = ssdm_pkg::DIV_W;
  localparam int DVS_W = ssdm_pkg::DVS_W;
  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DIV_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DVS_W:0]   t1;
  logic [DVS_W:0]   r1;
  logic [DVS_W:0]   t2;
  logic [DVS_W:0]   r2;
  logic             ge1;
  logic             ge2;

  // two restoring steps per cycle
  always_comb begin
    t1  = {rem, quo[DIV_W-1]};
    ge1 = (t1 >= {1'b0, dvs});
    r1  = ge1 ? (t1 - {1'b0, dvs}) : t1;
    t2  = {r1[DVS_W-1:0], quo[DIV_W-2]};
    ge2 = (t2 >= {1'b0, dvs});
    r2  = ge2 ? (t2 - {1'b0, dvs}) : t2;
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
      cnt <= '0;
    end else if (busy) begin
      rem <= r2[DVS_W-1:0];
      quo <= {quo[DIV_W-3:0], ge1, ge2};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == LAST)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* rtl/ssdm_back.sv */
module ssdm_back #(
  parameter int TRIGGER_MAX = 255
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ssdm_pkg::ssdm_cfg_t     cfg,
  input  ssdm_pkg::ssdm_cmd_t     cmd_in,
  input  logic                    cmd_empty,
  output logic                    cmd_pop,
  output ssdm_pkg::ssdm_div_req_t div_req,
  input  ssdm_pkg::ssdm_div_rsp_t div_rsp,
  input  logic                    pop,
  output logic                    empty,
  output ssdm_pkg::ssdm_out_t     out_item
);

  localparam int DIV_W   = ssdm_pkg::DIV_W;
  localparam int DVS_W   = ssdm_pkg::DVS_W;
  localparam int SPEED_W = ssdm_pkg::SPEED_W;

  ssdm_pkg::ssdm_bk_state_t state;
  ssdm_pkg::ssdm_bk_state_t state_next;
  ssdm_pkg::ssdm_cmd_t      cmd;

  logic               sl_neg;
  logic [SPEED_W-1:0] sl_mag;
  logic               sr_neg;
  logic [SPEED_W-1:0] sr_mag;
  logic [7:0]         left_duty;
  logic [7:0]         right_duty;
  logic [7:0]         held_left;
  logic [7:0]         held_right;
  logic               out_valid;
  logic               out_free;
  logic               is_drive;

  logic [22:0]        speed_prod;
  logic [34:0]        inner_prod;
  logic [28:0]        duty_prod;
  logic               span_neg;
  logic [9:0]         span_mag;
  logic [SPEED_W-1:0] duty_mag;
  logic [SPEED_W-1:0] q_speed;
  logic [7:0]         duty_q;

  logic signed [17:0] aux;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign is_drive = (cmd.op == ssdm_pkg::OP_STRAIGHT) || (cmd.op == ssdm_pkg::OP_TURN_RIGHT) ||
                    (cmd.op == ssdm_pkg::OP_TURN_LEFT);

  assign span_neg   = (cfg.duty_full < cfg.duty_floor);
  assign span_mag   = span_neg ? (cfg.duty_floor - cfg.duty_full) : (cfg.duty_full - cfg.duty_floor);
  assign duty_mag   = (state == ssdm_pkg::BK_DUTY_L_GO) ? sl_mag : sr_mag;
  assign speed_prod = cmd.diff_mag * ssdm_pkg::Q8_FULL;
  assign inner_prod = sl_mag * cmd.turn_num;
  assign duty_prod  = span_mag * duty_mag;
  assign q_speed    = div_rsp.quotient[SPEED_W-1:0];

  // floor plus the signed span share, clamped to ten bits, two bits dropped
  always_comb begin
    if (span_neg) begin
      aux = signed'({8'd0, cfg.duty_floor}) - signed'({3'd0, div_rsp.quotient[14:0]});
    end else begin
      aux = signed'({8'd0, cfg.duty_floor}) + signed'({3'd0, div_rsp.quotient[14:0]});
    end
    if (aux < 0) begin
      duty_q = 8'd0;
    end else if (aux > 18'sd1023) begin
      duty_q = 8'd255;
    end else begin
      duty_q = aux[9:2];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ssdm_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          state_next = ssdm_pkg::BK_DECODE;
        end
      end
      ssdm_pkg::BK_DECODE: begin
        if (cmd.op == ssdm_pkg::OP_BRAKE) begin
          state_next = ssdm_pkg::BK_EMIT;
        end else if (is_drive) begin
          state_next = ssdm_pkg::BK_SPEED;
        end else begin
          state_next = ssdm_pkg::BK_DUTY_L_GO;
        end
      end
      ssdm_pkg::BK_SPEED: begin
        if (div_rsp.done) begin
          if (cmd.op == ssdm_pkg::OP_STRAIGHT) begin
            state_next = ssdm_pkg::BK_DUTY_L_GO;
          end else begin
            state_next = ssdm_pkg::BK_INNER_GO;
          end
        end
      end
      ssdm_pkg::BK_INNER_GO: state_next = ssdm_pkg::BK_INNER;
      ssdm_pkg::BK_INNER: begin
        if (div_rsp.done) begin
          state_next = ssdm_pkg::BK_DUTY_L_GO;
        end
      end
      ssdm_pkg::BK_DUTY_L_GO: state_next = ssdm_pkg::BK_DUTY_L;
      ssdm_pkg::BK_DUTY_L: begin
        if (div_rsp.done) begin
          state_next = ssdm_pkg::BK_DUTY_R_GO;
        end
      end
      ssdm_pkg::BK_DUTY_R_GO: state_next = ssdm_pkg::BK_DUTY_R;
      ssdm_pkg::BK_DUTY_R: begin
        if (div_rsp.done) begin
          state_next = ssdm_pkg::BK_EMIT;
        end
      end
      ssdm_pkg::BK_EMIT: begin
        if (out_free) begin
          state_next = ssdm_pkg::BK_IDLE;
        end
      end
      default: state_next = ssdm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      ssdm_pkg::BK_IDLE: cmd_pop = !cmd_empty;
      ssdm_pkg::BK_DECODE: begin
        div_req.start    = is_drive;
        div_req.dividend = DIV_W'(speed_prod);
        div_req.divisor  = DVS_W'(TRIGGER_MAX);
      end
      ssdm_pkg::BK_INNER_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = inner_prod[DIV_W-1:0];
        div_req.divisor  = {1'b0, cmd.turn_den};
      end
      ssdm_pkg::BK_DUTY_L_GO, ssdm_pkg::BK_DUTY_R_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(duty_prod);
        div_req.divisor  = {2'b00, ssdm_pkg::Q8_FULL};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssdm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ssdm_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          cmd <= cmd_in;
        end
      end
      ssdm_pkg::BK_DECODE: begin
        sl_neg <= (cmd.op == ssdm_pkg::OP_SPIN_LEFT);
        sr_neg <= (cmd.op == ssdm_pkg::OP_SPIN_RIGHT);
        if (cmd.op == ssdm_pkg::OP_STOP) begin
          sl_mag <= '0;
          sr_mag <= '0;
        end else begin
          sl_mag <= SPEED_W'({cfg.spin_speed, 8'd0});
          sr_mag <= SPEED_W'({cfg.spin_speed, 8'd0});
        end
      end
      ssdm_pkg::BK_SPEED: begin
        if (div_rsp.done) begin
          sl_neg <= cmd.diff_neg;
          sr_neg <= cmd.diff_neg;
          sl_mag <= q_speed;
          sr_mag <= q_speed;
        end
      end
      ssdm_pkg::BK_INNER: begin
        if (div_rsp.done) begin
          if (cmd.op == ssdm_pkg::OP_TURN_RIGHT) begin
            sr_mag <= sr_mag - q_speed;
          end else begin
            sl_mag <= sl_mag - q_speed;
          end
        end
      end
      ssdm_pkg::BK_DUTY_L: begin
        if (div_rsp.done) begin
          left_duty <= duty_q;
        end
      end
      ssdm_pkg::BK_DUTY_R: begin
        if (div_rsp.done) begin
          right_duty <= duty_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      held_left  <= 8'd0;
      held_right <= 8'd0;
    end else if ((state == ssdm_pkg::BK_EMIT) && out_free) begin
      out_valid <= 1'b1;
      if (cmd.op == ssdm_pkg::OP_BRAKE) begin
        out_item.left_mode  <= ssdm_pkg::MODE_BRAKE;
        out_item.left_duty  <= held_left;
        out_item.right_mode <= ssdm_pkg::MODE_BRAKE;
        out_item.right_duty <= held_right;
      end else begin
        out_item.left_mode  <= (sl_neg && (sl_mag != '0)) ? ssdm_pkg::MODE_REVERSE
                                                           : ssdm_pkg::MODE_FORWARD;
        out_item.left_duty  <= left_duty;
        out_item.right_mode <= (sr_neg && (sr_mag != '0)) ? ssdm_pkg::MODE_REVERSE
                                                           : ssdm_pkg::MODE_FORWARD;
        out_item.right_duty <= right_duty;
        held_left           <= left_duty;
        held_right          <= right_duty;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/skid_steer_drive_mixer_core.sv */
// Skid-steer drive mixer: trigger pair and stick X in, bridge mode and PWM duty per side out.
// Input channel: an item is taken on a clock edge with push high and full low.
// Result channel: while empty is low the oldest result sits on out_item; pop takes it.
// Configuration: cfg_valid with cfg_index/cfg_data writes one register; cfg_ready is
// always high. Write registers only while no transaction is in flight.
// One result per input item, in order.
// Work per item depends on the command: a brake needs no division, spin or stop two,
// straight driving three and a turn four, all on the shared divider (two quotient bits
// per cycle, up to four divisions per item: speed, inner side, two duties).
// Items are worked one at a time; a two-entry command queue between the classifying
// front and the arithmetic back lets input keep arriving meanwhile.
// A stalled receiver holds the finished result in the output register; the back waits
// in its last step and the queue fills, then full rises.
// Reset: registers go to their defaults, queue and output are emptied, held duties clear.
module skid_steer_drive_mixer_core #(
  parameter int TRIGGER_MAX = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ssdm_pkg::ssdm_in_t  in_item,
  output logic                empty,
  input  logic                pop,
  output ssdm_pkg::ssdm_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  ssdm_pkg::ssdm_cfg_t     cfg;
  ssdm_pkg::ssdm_cmd_t     front_cmd;
  ssdm_pkg::ssdm_cmd_t     queue_cmd;
  ssdm_pkg::ssdm_div_req_t div_req;
  ssdm_pkg::ssdm_div_rsp_t div_rsp;
  logic                    queue_empty;
  logic                    queue_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone       <= 15'd1200;
      cfg.spin_threshold <= 15'd15000;
      cfg.spin_speed     <= 7'd50;
      cfg.duty_full      <= 10'd320;
      cfg.duty_floor     <= 10'd21;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssdm_pkg::CFG_DEADZONE:       cfg.deadzone       <= cfg_data[14:0];
        ssdm_pkg::CFG_SPIN_THRESHOLD: cfg.spin_threshold <= cfg_data[14:0];
        ssdm_pkg::CFG_SPIN_SPEED:     cfg.spin_speed     <= cfg_data[6:0];
        ssdm_pkg::CFG_DUTY_FULL:      cfg.duty_full      <= cfg_data[9:0];
        ssdm_pkg::CFG_DUTY_FLOOR:     cfg.duty_floor     <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  ssdm_front #(
    .TRIGGER_MAX(TRIGGER_MAX)
  ) u_front (
    .item          (in_item),
    .deadzone      (cfg.deadzone),
    .spin_threshold(cfg.spin_threshold),
    .cmd           (front_cmd)
  );

  ssdm_fifo u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push && !full),
    .wr_data(front_cmd),
    .full   (full),
    .rd_en  (queue_pop),
    .rd_data(queue_cmd),
    .empty  (queue_empty)
  );

  ssdm_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  ssdm_back #(
    .TRIGGER_MAX(TRIGGER_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_in   (queue_cmd),
    .cmd_empty(queue_empty),
    .cmd_pop  (queue_pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

/* rtl/ssdm_checker.sv */
`include "assert_macros.svh"

module ssdm_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input ssdm_pkg::ssdm_out_t out_item
);

  `ASSERT_RST(a_reset_drains, clk, rst |=> empty && !full, "queues not empty after reset")
  `ASSERT_ON(a_brake_paired, clk, rst, !empty |-> ((out_item.left_mode == ssdm_pkg::MODE_BRAKE) == (out_item.right_mode == ssdm_pkg::MODE_BRAKE)), "brake on one side only")
  `ASSERT_ON(a_result_holds, clk, rst, !empty && !pop |=> !empty && $stable(out_item), "waiting result changed")

endmodule

bind skid_steer_drive_mixer_core ssdm_checker u_checker (.*);

/* tb/sv/tb_skid_steer_drive_mixer_core.sv */
module tb_skid_steer_drive_mixer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ssdm_pkg::*;

  localparam int TRIG_MAX = 255;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [2:0] CFG_NONE = 3'd5;

  logic clk;
  logic rst;
  logic push = 1'b0;
  logic full;
  ssdm_in_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  ssdm_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ssdm_in_t sample_q[$];
  ssdm_out_t drive_q[$];

  ssdm_cfg_t exp_cfg;
  logic [7:0] held_left;
  logic [7:0] held_right;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_kick = 1'b0;
  int rx_hold_left = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  skid_steer_drive_mixer_core #(
    .TRIGGER_MAX(TRIG_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint inner_side(longint s, longint num, longint den);
    if (den <= 0) return s;
    return s - (s * num) / den;
  endfunction

  function automatic logic [7:0] duty_count(longint s);
    longint mag;
    longint span;
    longint aux;
    mag = (s < 0) ? -s : s;
    span = longint'(exp_cfg.duty_full) - longint'(exp_cfg.duty_floor);
    aux = longint'(exp_cfg.duty_floor) + (span * mag) / longint'(Q8_FULL);
    if (aux < 0) aux = 0;
    if (aux > 1023) aux = 1023;
    return aux[9:2];
  endfunction

  // expected bridge modes and duties, updates the held duties
  function automatic ssdm_out_t mix_drive(ssdm_in_t s);
    ssdm_out_t r;
    longint tl;
    longint tr;
    longint x;
    longint dz;
    longint sp;
    longint th;
    longint spd;
    longint sl;
    longint sr;
    tl = longint'(s.trigger_left);
    tr = longint'(s.trigger_right);
    x = longint'($signed(s.joystick_x));
    dz = longint'(exp_cfg.deadzone);
    if (tl == TRIG_MAX && tr == TRIG_MAX) begin
      r.left_mode = MODE_BRAKE;
      r.left_duty = held_left;
      r.right_mode = MODE_BRAKE;
      r.right_duty = held_right;
      return r;
    end
    if (tl == 0 && tr == 0) begin
      sp = longint'(exp_cfg.spin_speed) * 256;
      th = longint'(exp_cfg.spin_threshold);
      if (x > th) begin
        sl = sp;
        sr = -sp;
      end else if (x < -th) begin
        sl = -sp;
        sr = sp;
      end else begin
        sl = 0;
        sr = 0;
      end
    end else begin
      spd = ((tr - tl) * 100 * 256) / longint'(TRIG_MAX);
      if (x > dz) begin
        sl = spd;
        sr = inner_side(spd, x - dz, 32767 - dz);
      end else if (x < -dz) begin
        sr = spd;
        sl = inner_side(spd, -(x + dz), 32768 - dz);
      end else begin
        sl = spd;
        sr = spd;
      end
    end
    held_left = duty_count(sl);
    held_right = duty_count(sr);
    r.left_mode = (sl >= 0) ? MODE_FORWARD : MODE_REVERSE;
    r.left_duty = held_left;
    r.right_mode = (sr >= 0) ? MODE_FORWARD : MODE_REVERSE;
    r.right_duty = held_right;
    return r;
  endfunction

  // sender side
  always @(posedge clk) begin : sample_drv
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        drive_q.push_back(mix_drive(in_item));
        void'(sample_q.pop_front());
      end
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        push <= 1'b1;
        in_item <= sample_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin : rx_hold
    if (hold_kick) rx_hold_left <= HOLD_CYCLES;
    else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  // receiver side and checking
  always @(posedge clk) begin : result_mon
    ssdm_out_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (drive_q.size() == 0) begin
          fail_cnt = fail_cnt + 1;
          if (fail_cnt <= 10)
            $display("unexpected transaction: %0d/%0d %0d/%0d", out_item.left_mode,
                     out_item.left_duty, out_item.right_mode, out_item.right_duty);
        end else begin
          want = drive_q.pop_front();
          if (out_item.left_mode !== want.left_mode || out_item.left_duty !== want.left_duty ||
              out_item.right_mode !== want.right_mode ||
              out_item.right_duty !== want.right_duty) begin
            fail_cnt = fail_cnt + 1;
            if (fail_cnt <= 10)
              $display("mismatch: exp %0d/%0d %0d/%0d got %0d/%0d %0d/%0d",
                       want.left_mode, want.left_duty, want.right_mode, want.right_duty,
                       out_item.left_mode, out_item.left_duty, out_item.right_mode,
                       out_item.right_duty);
          end
        end
      end
      pop <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_skid_steer_drive_mixer_core NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DEADZONE:       exp_cfg.deadzone = data[14:0];
      CFG_SPIN_THRESHOLD: exp_cfg.spin_threshold = data[14:0];
      CFG_SPIN_SPEED:     exp_cfg.spin_speed = data[6:0];
      CFG_DUTY_FULL:      exp_cfg.duty_full = data[9:0];
      CFG_DUTY_FLOOR:     exp_cfg.duty_floor = data[9:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(int dz, int th, int sp, int df, int fl);
    write_reg(CFG_DEADZONE, 16'(dz));
    write_reg(CFG_SPIN_THRESHOLD, 16'(th));
    write_reg(CFG_SPIN_SPEED, 16'(sp));
    write_reg(CFG_DUTY_FULL, 16'(df));
    write_reg(CFG_DUTY_FLOOR, 16'(fl));
  endtask

  // random values with upper bits set too, plus a write to an unused index
  task automatic load_random_cfg();
    write_reg(CFG_DEADZONE, 16'($urandom_range(0, 65535)));
    write_reg(3'(CFG_NONE + $urandom_range(0, 2)), 16'($urandom_range(0, 65535)));
    write_reg(CFG_SPIN_THRESHOLD, 16'($urandom_range(0, 65535)));
    write_reg(CFG_SPIN_SPEED, 16'($urandom_range(0, 65535)));
    write_reg(CFG_DUTY_FULL, 16'($urandom_range(0, 65535)));
    write_reg(CFG_DUTY_FLOOR, 16'($urandom_range(0, 65535)));
  endtask

  task automatic add_sample(int tl, int tr, int x);
    ssdm_in_t s;
    s.trigger_left = 8'(tl);
    s.trigger_right = 8'(tr);
    s.joystick_x = 16'(x);
    sample_q.push_back(s);
  endtask

  function automatic int clamp_stick(int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  task automatic add_random(int n);
    int tl;
    int tr;
    int x;
    int kind;
    for (int i = 0; i < n; i++) begin
      tl = $urandom_range(0, 255);
      tr = $urandom_range(0, 255);
      x = int'($urandom_range(0, 65535)) - 32768;
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          tl = TRIG_MAX;
          tr = TRIG_MAX;
        end
        1: begin
          tl = 0;
          tr = 0;
        end
        2: begin
          tl = 0;
          tr = 0;
          x = int'(exp_cfg.spin_threshold) + int'($urandom_range(0, 4)) - 2;
          if ($urandom_range(0, 1) != 0) x = -x;
        end
        3: begin
          x = int'(exp_cfg.deadzone) + int'($urandom_range(0, 4)) - 2;
          if ($urandom_range(0, 1) != 0) x = -x;
        end
        4: x = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        5: if ($urandom_range(0, 1) != 0) tl = ($urandom_range(0, 1) != 0) ? TRIG_MAX : 0;
           else tr = ($urandom_range(0, 1) != 0) ? TRIG_MAX : 0;
        default: ;
      endcase
      add_sample(tl, tr, clamp_stick(x));
    end
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle(int tx, int rx);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
  endtask

  initial begin
    exp_cfg.deadzone = 15'd1200;
    exp_cfg.spin_threshold = 15'd15000;
    exp_cfg.spin_speed = 7'd50;
    exp_cfg.duty_full = 10'd320;
    exp_cfg.duty_floor = 10'd21;
    held_left = '0;
    held_right = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, directed cases first
    set_idle(0, 0);
    add_sample(255, 255, 0);
    add_sample(0, 0, 0);
    add_sample(0, 0, 32767);
    add_sample(0, 0, -32768);
    add_sample(0, 0, 15000);
    add_sample(0, 0, -15000);
    add_sample(0, 0, 15001);
    add_sample(0, 0, -15001);
    add_sample(0, 255, 0);
    add_sample(255, 0, 0);
    add_sample(255, 254, 0);
    add_sample(128, 128, 32767);
    add_sample(0, 255, 32767);
    add_sample(0, 255, -32768);
    add_sample(255, 0, 32767);
    add_sample(255, 0, -32768);
    add_sample(10, 200, 1200);
    add_sample(10, 200, -1200);
    add_sample(10, 200, 1201);
    add_sample(10, 200, -1201);
    add_sample(255, 255, -32768);
    add_sample(1, 0, -1);
    add_sample(0, 1, 1);
    add_sample(254, 255, 12345);
    add_sample(255, 255, 32767);
    add_random(110);
    drain();

    // low extremes, receiver held off while samples keep coming
    load_cfg(0, 0, 100, 1023, 0);
    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    add_random(120);
    drain();

    // high extremes, floor above full, spin above 100 percent
    set_idle(48, 0);
    load_cfg(32767, 32767, 127, 0, 1023);
    add_random(120);
    drain();

    set_idle(0, 48);
    load_random_cfg();
    add_random(120);
    drain();

    // defaults again, sender waits for every result midway
    set_idle(9, 9);
    load_cfg(1200, 15000, 50, 320, 21);
    add_random(60);
    drain();
    add_random(60);
    drain();

    set_idle(0, 0);
    load_random_cfg();
    add_random(120);
    drain();

    set_idle(48, 0);
    load_cfg(32000, 0, 0, 1023, 1023);
    add_random(100);
    drain();

    set_idle(9, 9);
    load_random_cfg();
    add_random(100);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (drive_q.size() != 0) fail_cnt = fail_cnt + 1;
    if (fail_cnt == 0) begin
      $display("tb_skid_steer_drive_mixer_core OK");
    end else begin
      $display("tb_skid_steer_drive_mixer_core NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ssdm_pkg.sv
rtl/ssdm_front.sv
rtl/ssdm_fifo.sv
rtl/ssdm_div.sv
rtl/ssdm_back.sv
rtl/skid_steer_drive_mixer_core.sv
rtl/ssdm_checker.sv
tb/sv/tb_skid_steer_drive_mixer_core.sv
